// ----- rtl/tstw_pkg.sv -----
package tstw_pkg;

  // The node and sample fields are 10 bits wide, so both memories hold 1024 entries.
  localparam int unsigned NODE_COUNT = 1024;
  localparam int unsigned SERIES_MAX = 1024;
  localparam int unsigned NODE_AW    = 10;
  localparam int unsigned SERIES_AW  = 10;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned DEPTH_W    = 6;
  localparam int unsigned CFG_W      = 11;

  localparam logic [LEN_W-1:0]   SERIES_LENGTH_RST = 11'd1024;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST     = 6'd63;

  // Function codes of an input beat.
  localparam logic [1:0] FUNC_NODE_WR   = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE_WR = 2'd1;
  localparam logic [1:0] FUNC_WALK      = 2'd2;

  // Node kinds; the fourth code acts as a terminal.
  localparam logic [1:0] KIND_TERMINAL = 2'd0;
  localparam logic [1:0] KIND_SAMPLE   = 2'd1;
  localparam logic [1:0] KIND_DIFF     = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_SERIES_LENGTH = 1'b0;
  localparam logic CFG_MAX_DEPTH     = 1'b1;

  typedef struct packed {
    logic [1:0]         func;
    logic [9:0]         node_index;
    logic [1:0]         node_kind;
    logic [5:0]         node_depth;
    logic [9:0]         left_child;
    logic [9:0]         right_child;
    logic [9:0]         split_offset;
    logic signed [31:0] threshold;
    logic signed [31:0] leaf_value;
    logic [9:0]         position;
    logic signed [31:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         final_node;
    logic signed [31:0] final_value;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         depth;
    logic [9:0]         split_offset;
    logic [9:0]         left_child;
    logic [9:0]         right_child;
    logic signed [31:0] threshold;
    logic signed [31:0] leaf_value;
  } node_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NODE,
    ST_DIV,
    ST_RD_A,
    ST_RD_B,
    ST_CMP
  } state_e;

endpackage

// ----- rtl/time_series_tree_walk_core.sv -----
// Node and sample writes are taken in the idle state. Each move of a walk reads the
// node memory, runs the 4-bit-per-cycle remainder unit, and reads the sample memory
// once on a sample split and twice on a difference split.
// One item is in work at a time; a finished result waits in the output register while
// the next item is accepted. Reset clears control state and sets the configuration
// registers to series length 1024 and max depth 63; both memories are undefined until written.
module time_series_tree_walk_core #(
  parameter int unsigned DEPTH_MAX = 63
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tstw_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tstw_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [tstw_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned MOVE_W = $clog2(DEPTH_MAX + 1);
  localparam int unsigned CAP_W  = (MOVE_W > tstw_pkg::DEPTH_W) ? MOVE_W : tstw_pkg::DEPTH_W;
  localparam logic [CAP_W-1:0] DEPTH_MAX_C = CAP_W'(DEPTH_MAX);
  localparam int unsigned LW = tstw_pkg::LEN_W;

  // Memories.
  tstw_pkg::node_t    node_mem [tstw_pkg::NODE_COUNT];
  logic signed [31:0] smp_mem  [tstw_pkg::SERIES_MAX];

  tstw_pkg::state_e state_q, state_d;
  logic [tstw_pkg::NODE_AW-1:0] k_q, k_d;
  logic [MOVE_W-1:0]   moves_q, moves_d;
  logic [9:0]          j_q, j_d;
  logic [LW-1:0]       len_q, len_d;
  logic [CAP_W-1:0]    cap_q, cap_d;
  logic [LW-1:0]       rem_q, rem_d;
  logic [11:0]         dvd_q, dvd_d;
  logic [1:0]          cnt_q, cnt_d;
  logic signed [31:0]  xa_q, xa_d;
  logic                out_valid_q, out_valid_d;
  tstw_pkg::out_item_t out_data_q, out_data_d;
  logic [LW-1:0]       series_length_q;
  logic [tstw_pkg::DEPTH_W-1:0] max_depth_q;

  tstw_pkg::node_t    node_rdata_q;
  logic signed [31:0] smp_rdata_q;
  logic                          node_re, smp_re, node_we, smp_we;
  logic [tstw_pkg::NODE_AW-1:0]  node_raddr;
  logic [tstw_pkg::SERIES_AW-1:0] smp_raddr;
  tstw_pkg::node_t    node_wdata;

  logic            out_free;
  logic [LW-1:0]   s_sum, len_m1, p_val, len_clamp, r_next;
  logic [LW:0]     trial;
  logic [LW-1:0]   rem_c;
  logic [11:0]     dvd_c;
  logic            stop_walk, go_left;
  logic signed [32:0] diff_val;
  logic [tstw_pkg::NODE_AW-1:0] child;

  assign out_free = !out_valid_q || !out_stall_i;

  assign node_wdata.kind         = in_data_i.node_kind;
  assign node_wdata.depth        = in_data_i.node_depth;
  assign node_wdata.split_offset = in_data_i.split_offset;
  assign node_wdata.left_child   = in_data_i.left_child;
  assign node_wdata.right_child  = in_data_i.right_child;
  assign node_wdata.threshold    = in_data_i.threshold;
  assign node_wdata.leaf_value   = in_data_i.leaf_value;

  always_comb begin
    if (series_length_q < LW'(2)) begin
      len_clamp = LW'(2);
    end else if (series_length_q > LW'(tstw_pkg::SERIES_MAX)) begin
      len_clamp = LW'(tstw_pkg::SERIES_MAX);
    end else begin
      len_clamp = series_length_q;
    end
  end

  // Segment index and the wrapped start of a difference pair.
  assign s_sum  = {1'b0, node_rdata_q.split_offset} + {1'b0, j_q};
  assign len_m1 = len_q - LW'(1);
  assign p_val  = (node_rdata_q.kind == tstw_pkg::KIND_DIFF && s_sum >= len_m1) ?
                  (s_sum + LW'(1) - len_q) : s_sum;

  // Four restoring remainder steps per cycle.
  always_comb begin
    rem_c = rem_q;
    dvd_c = dvd_q;
    trial = '0;
    for (int i = 0; i < 4; i++) begin
      trial = {rem_c, dvd_c[11]};
      dvd_c = {dvd_c[10:0], 1'b0};
      if (trial >= {1'b0, len_q}) begin
        trial = trial - {1'b0, len_q};
      end
      rem_c = trial[LW-1:0];
    end
  end

  assign r_next = (rem_q + LW'(1) == len_q) ? '0 : (rem_q + LW'(1));

  assign stop_walk = ({{(CAP_W-MOVE_W){1'b0}}, moves_q} >= cap_q) ||
                     (node_rdata_q.kind != tstw_pkg::KIND_SAMPLE &&
                      node_rdata_q.kind != tstw_pkg::KIND_DIFF) ||
                     (node_rdata_q.depth >= max_depth_q);

  assign diff_val = {smp_rdata_q[31], smp_rdata_q} - {xa_q[31], xa_q};

  always_comb begin
    if (state_q == tstw_pkg::ST_CMP) begin
      go_left = diff_val <= $signed({node_rdata_q.threshold[31], node_rdata_q.threshold});
    end else begin
      go_left = smp_rdata_q <= node_rdata_q.threshold;
    end
  end

  assign child = go_left ? node_rdata_q.left_child : node_rdata_q.right_child;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    moves_d     = moves_q;
    j_d         = j_q;
    len_d       = len_q;
    cap_d       = cap_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    cnt_d       = cnt_q;
    xa_d        = xa_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    in_stall_o  = 1'b1;
    node_re     = 1'b0;
    node_raddr  = k_q;
    node_we     = 1'b0;
    smp_re      = 1'b0;
    smp_raddr   = rem_q[tstw_pkg::SERIES_AW-1:0];
    smp_we      = 1'b0;
    case (state_q)
      tstw_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (in_data_i.func)
            tstw_pkg::FUNC_NODE_WR:   node_we = 1'b1;
            tstw_pkg::FUNC_SAMPLE_WR: smp_we  = 1'b1;
            tstw_pkg::FUNC_WALK: begin
              node_re    = 1'b1;
              node_raddr = '0;
              k_d        = '0;
              moves_d    = '0;
              j_d        = in_data_i.position;
              len_d      = len_clamp;
              cap_d      = ({{(CAP_W-tstw_pkg::DEPTH_W){1'b0}}, max_depth_q} < DEPTH_MAX_C) ?
                           {{(CAP_W-tstw_pkg::DEPTH_W){1'b0}}, max_depth_q} : DEPTH_MAX_C;
              state_d    = tstw_pkg::ST_NODE;
            end
            default: ;
          endcase
        end
      end
      tstw_pkg::ST_NODE: begin
        if (stop_walk) begin
          if (out_free) begin
            out_valid_d            = 1'b1;
            out_data_d.final_node  = k_q;
            out_data_d.final_value = node_rdata_q.leaf_value;
            state_d                = tstw_pkg::ST_IDLE;
          end
        end else begin
          rem_d   = '0;
          dvd_d   = {1'b0, p_val};
          cnt_d   = '0;
          state_d = tstw_pkg::ST_DIV;
        end
      end
      tstw_pkg::ST_DIV: begin
        rem_d = rem_c;
        dvd_d = dvd_c;
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          state_d = tstw_pkg::ST_RD_A;
        end
      end
      tstw_pkg::ST_RD_A: begin
        smp_re  = 1'b1;
        state_d = tstw_pkg::ST_RD_B;
      end
      tstw_pkg::ST_RD_B: begin
        if (node_rdata_q.kind == tstw_pkg::KIND_DIFF) begin
          xa_d      = smp_rdata_q;
          smp_re    = 1'b1;
          smp_raddr = r_next[tstw_pkg::SERIES_AW-1:0];
          state_d   = tstw_pkg::ST_CMP;
        end else begin
          k_d        = child;
          moves_d    = moves_q + MOVE_W'(1);
          node_re    = 1'b1;
          node_raddr = child;
          state_d    = tstw_pkg::ST_NODE;
        end
      end
      tstw_pkg::ST_CMP: begin
        k_d        = child;
        moves_d    = moves_q + MOVE_W'(1);
        node_re    = 1'b1;
        node_raddr = child;
        state_d    = tstw_pkg::ST_NODE;
      end
      default: state_d = tstw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= tstw_pkg::ST_IDLE;
      out_valid_q     <= 1'b0;
      cnt_q           <= '0;
      moves_q         <= '0;
      series_length_q <= tstw_pkg::SERIES_LENGTH_RST;
      max_depth_q     <= tstw_pkg::MAX_DEPTH_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      moves_q     <= moves_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          tstw_pkg::CFG_SERIES_LENGTH: series_length_q <= cfg_wdata_i[LW-1:0];
          tstw_pkg::CFG_MAX_DEPTH:     max_depth_q <= cfg_wdata_i[tstw_pkg::DEPTH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    j_q        <= j_d;
    len_q      <= len_d;
    cap_q      <= cap_d;
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    xa_q       <= xa_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[in_data_i.node_index] <= node_wdata;
    end
    if (node_re) begin
      node_rdata_q <= node_mem[node_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_we) begin
      smp_mem[in_data_i.position] <= in_data_i.sample_value;
    end
    if (smp_re) begin
      smp_rdata_q <= smp_mem[smp_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- tb/tb_time_series_tree_walk_core.sv -----
`timescale 1ns / 100ps

module tb_time_series_tree_walk_core;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] FUNC_NONE   = 2'd3;
  localparam int unsigned WALK_CAP    = 63;
  localparam int unsigned IDLE_PCT    = 12;
  localparam int unsigned ITEM_TARGET = 1050;
  localparam int unsigned TAIL_CYCLES = 600;
  localparam int unsigned HOLD_CYCLES = 400;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  tstw_pkg::in_item_t          in_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  tstw_pkg::out_item_t         out_data;
  logic                        cfg_we = 1'b0;
  logic                        cfg_index = tstw_pkg::CFG_SERIES_LENGTH;
  logic [tstw_pkg::CFG_W-1:0]  cfg_wdata = '0;

  // Shadow copy of the block's memories and registers.
  tstw_pkg::node_t              node_mem [tstw_pkg::NODE_COUNT];
  bit                           node_written [tstw_pkg::NODE_COUNT];
  logic signed [31:0]           sample_mem [tstw_pkg::SERIES_MAX];
  bit                           sample_written [tstw_pkg::SERIES_MAX];
  logic [tstw_pkg::LEN_W-1:0]   cfg_len = tstw_pkg::SERIES_LENGTH_RST;
  logic [tstw_pkg::DEPTH_W-1:0] cfg_depth = tstw_pkg::MAX_DEPTH_RST;

  tstw_pkg::out_item_t walk_results_q[$];
  int        tree_nodes[$];
  int        errors = 0;
  int        items_sent = 0;
  bit        quiet = 1'b0;
  int        hold_left = 0;

  time_series_tree_walk_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(100_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // Walks the shadow tree. Returns 0 and names the first unwritten entry it would read.
  function automatic bit walk_tree_model(input logic [9:0] j,
                                         output tstw_pkg::out_item_t res,
                                         output int miss_node, output int miss_sample);
    int unsigned len, cap, k, moves, s, p, i0, i1;
    logic signed [32:0] val, thr;
    logic signed [31:0] x0, x1;
    tstw_pkg::node_t nd;
    miss_node = -1;
    miss_sample = -1;
    res = '0;
    len = cfg_len;
    if (len < 2) len = 2;
    if (len > tstw_pkg::SERIES_MAX) len = tstw_pkg::SERIES_MAX;
    cap = (cfg_depth < WALK_CAP) ? cfg_depth : WALK_CAP;
    k = 0;
    moves = 0;
    while (1) begin
      if (!node_written[k]) begin
        miss_node = k;
        return 1'b0;
      end
      nd = node_mem[k];
      if (moves >= cap) break;
      if (nd.kind != tstw_pkg::KIND_SAMPLE && nd.kind != tstw_pkg::KIND_DIFF) break;
      if (nd.depth >= cfg_depth) break;
      s = int'(nd.split_offset) + int'(j);
      if (nd.kind == tstw_pkg::KIND_SAMPLE) begin
        i0 = s % len;
        if (!sample_written[i0]) begin
          miss_sample = i0;
          return 1'b0;
        end
        x0 = sample_mem[i0];
        val = {x0[31], x0};
      end else begin
        p = (s >= len - 1) ? s + 1 - len : s;
        i0 = p % len;
        i1 = (p + 1) % len;
        if (!sample_written[i0]) begin
          miss_sample = i0;
          return 1'b0;
        end
        if (!sample_written[i1]) begin
          miss_sample = i1;
          return 1'b0;
        end
        x0 = sample_mem[i0];
        x1 = sample_mem[i1];
        val = {x1[31], x1} - {x0[31], x0};
      end
      thr = {nd.threshold[31], nd.threshold};
      k = (val <= thr) ? nd.left_child : nd.right_child;
      moves++;
    end
    res.final_node  = k[9:0];
    res.final_value = nd.leaf_value;
    return 1'b1;
  endfunction

  function automatic tstw_pkg::in_item_t random_item();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(tstw_pkg::in_item_t)-1:0];
  endfunction

  // Mostly small Q16.16 values so that thresholds and samples land close together.
  function automatic logic signed [31:0] rand_q();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return int'($urandom_range(0, 524288)) - 262144;
  endfunction

  function automatic int pick_free(ref bit used [tstw_pkg::NODE_COUNT]);
    int k;
    do k = $urandom_range(1, tstw_pkg::NODE_COUNT - 1); while (used[k]);
    used[k] = 1'b1;
    return k;
  endfunction

  task automatic apply_item(input tstw_pkg::in_item_t it);
    tstw_pkg::node_t nd;
    tstw_pkg::out_item_t res;
    int mn, ms;
    case (it.func)
      tstw_pkg::FUNC_NODE_WR: begin
        nd.kind         = it.node_kind;
        nd.depth        = it.node_depth;
        nd.split_offset = it.split_offset;
        nd.left_child   = it.left_child;
        nd.right_child  = it.right_child;
        nd.threshold    = it.threshold;
        nd.leaf_value   = it.leaf_value;
        node_mem[it.node_index]     = nd;
        node_written[it.node_index] = 1'b1;
      end
      tstw_pkg::FUNC_SAMPLE_WR: begin
        sample_mem[it.position]     = it.sample_value;
        sample_written[it.position] = 1'b1;
      end
      tstw_pkg::FUNC_WALK: begin
        if (walk_tree_model(it.position, res, mn, ms)) begin
          walk_results_q.push_back(res);
        end else begin
          $error("walk at %0d sent over unwritten memory", it.position);
          errors++;
        end
      end
      default: ;
    endcase
  endtask

  // Offers one beat and holds it until accepted; valid stays high for a following beat.
  task automatic send_item(input tstw_pkg::in_item_t it);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    apply_item(it);
  endtask

  task automatic write_node(input logic [9:0] idx, input logic [1:0] kind,
                            input logic [5:0] depth, input logic [9:0] left,
                            input logic [9:0] right, input logic [9:0] offset,
                            input logic signed [31:0] thr, input logic signed [31:0] leaf);
    tstw_pkg::in_item_t it;
    it = random_item();
    it.func         = tstw_pkg::FUNC_NODE_WR;
    it.node_index   = idx;
    it.node_kind    = kind;
    it.node_depth   = depth;
    it.left_child   = left;
    it.right_child  = right;
    it.split_offset = offset;
    it.threshold    = thr;
    it.leaf_value   = leaf;
    send_item(it);
  endtask

  task automatic write_sample(input logic [9:0] pos, input logic signed [31:0] val);
    tstw_pkg::in_item_t it;
    it = random_item();
    it.func         = tstw_pkg::FUNC_SAMPLE_WR;
    it.position     = pos;
    it.sample_value = val;
    send_item(it);
  endtask

  task automatic fill_node(input logic [9:0] k);
    logic [1:0] kind;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) kind = tstw_pkg::KIND_TERMINAL;
    else if (pick == 5) kind = KIND_UNUSED;
    else if (pick < 8) kind = tstw_pkg::KIND_SAMPLE;
    else kind = tstw_pkg::KIND_DIFF;
    write_node(k, kind, 6'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
               rand_q(), $urandom);
  endtask

  // Writes whatever the walk would read unwritten, then sends the walk.
  task automatic run_walk(input logic [9:0] j);
    tstw_pkg::in_item_t it;
    tstw_pkg::out_item_t res;
    int mn, ms;
    bit ok;
    while (1) begin
      ok = walk_tree_model(j, res, mn, ms);
      if (ok) break;
      if (mn >= 0) fill_node(mn[9:0]);
      else write_sample(ms[9:0], rand_q());
    end
    it = random_item();
    it.func     = tstw_pkg::FUNC_WALK;
    it.position = j;
    send_item(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (walk_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [tstw_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tstw_pkg::CFG_SERIES_LENGTH) cfg_len = data;
    else cfg_depth = data[tstw_pkg::DEPTH_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_config(input logic [tstw_pkg::LEN_W-1:0] len,
                            input logic [tstw_pkg::DEPTH_W-1:0] depth);
    wait_idle();
    write_cfg(tstw_pkg::CFG_SERIES_LENGTH, len);
    // The upper data bits are don't-care for the depth register.
    write_cfg(tstw_pkg::CFG_MAX_DEPTH, {5'($urandom), depth});
  endtask

  // Builds a well-formed tree rooted at node 0 with node depths that match the structure.
  task automatic build_tree(input int size);
    bit used [tstw_pkg::NODE_COUNT];
    int depth_q[$];
    int i, k, d, l, r;
    used = '{default: 1'b0};
    used[0] = 1'b1;
    tree_nodes = {0};
    depth_q = {0};
    i = 0;
    while (i < tree_nodes.size()) begin
      k = tree_nodes[i];
      d = depth_q[i];
      if (tree_nodes.size() + 2 <= size && $urandom_range(0, 3) != 0) begin
        l = pick_free(used);
        r = pick_free(used);
        tree_nodes.push_back(l);
        tree_nodes.push_back(r);
        depth_q.push_back(d + 1);
        depth_q.push_back(d + 1);
        write_node(k[9:0], $urandom_range(0, 1) ? tstw_pkg::KIND_SAMPLE : tstw_pkg::KIND_DIFF,
                   d[5:0], l[9:0], r[9:0], 10'($urandom), rand_q(), $urandom);
      end else begin
        write_node(k[9:0],
                   ($urandom_range(0, 7) == 0) ? KIND_UNUSED : tstw_pkg::KIND_TERMINAL,
                   d[5:0], 10'($urandom), 10'($urandom), 10'($urandom), $urandom, $urandom);
      end
      i++;
    end
  endtask

  task automatic load_samples(input int len);
    for (int p = 0; p < len; p++) write_sample(p[9:0], rand_q());
  endtask

  task automatic test_directed_extremes();
    write_node(10'd0, tstw_pkg::KIND_SAMPLE, 6'd0, 10'd1, 10'd1023, 10'd1023, 32'sh7FFFFFFF,
               32'sh12345678);
    write_node(10'd1, tstw_pkg::KIND_TERMINAL, 6'd1, 10'd0, 10'd0, 10'd0, 32'sh0,
               32'sh80000000);
    write_node(10'd1023, KIND_UNUSED, 6'd63, 10'd1023, 10'd1023, 10'd1023, 32'sh0,
               32'sh7FFFFFFF);
    // Offset plus position wraps past the series end.
    write_sample(10'd1022, 32'sh7FFFFFFF);
    run_walk(10'd1023);
    write_node(10'd0, tstw_pkg::KIND_SAMPLE, 6'd0, 10'd1, 10'd1023, 10'd0, 32'sh80000000,
               32'sh0);
    write_sample(10'd0, 32'sh80000000);
    run_walk(10'd0);
    write_sample(10'd5, 32'sh80000001);
    run_walk(10'd5);
    // Difference splits at full scale need the 33-bit subtraction.
    write_node(10'd0, tstw_pkg::KIND_DIFF, 6'd0, 10'd1, 10'd1023, 10'd1023, 32'sh0, 32'sh1);
    write_sample(10'd0, 32'sh7FFFFFFF);
    write_sample(10'd1, 32'sh80000000);
    write_sample(10'd2, 32'sh7FFFFFFF);
    run_walk(10'd0);
    write_node(10'd0, tstw_pkg::KIND_DIFF, 6'd0, 10'd1, 10'd1023, 10'd1023, 32'sh7FFFFFFF,
               32'sh1);
    run_walk(10'd1);
  endtask

  task automatic test_special_cases();
    tstw_pkg::in_item_t it;
    // Lengths below two clamp to two, above the memory size to the memory size.
    set_config(11'd0, 6'd63);
    write_node(10'd0, tstw_pkg::KIND_SAMPLE, 6'd0, 10'd1, 10'd1023, 10'd1023, 32'sh0, 32'sh2);
    run_walk(10'd1);
    set_config(11'd2047, 6'd0);
    run_walk(10'($urandom));
    // A node whose stored depth reaches the limit ends the walk there.
    set_config(11'd1024, 6'd5);
    write_node(10'd0, tstw_pkg::KIND_SAMPLE, 6'd5, 10'd1, 10'd1, 10'd0, 32'sh0, 32'sh3);
    run_walk(10'd3);
    // A node that points to itself runs until the move cap.
    set_config(11'd1024, 6'd63);
    write_node(10'd0, tstw_pkg::KIND_SAMPLE, 6'd0, 10'd0, 10'd0, 10'd0, 32'sh0, 32'sh4);
    run_walk(10'd3);
    it = random_item();
    it.func = FUNC_NONE;
    send_item(it);
    run_walk(10'd700);
  endtask

  task automatic test_output_backpressure();
    set_config(11'd16, 6'd8);
    build_tree(7);
    load_samples(16);
    quiet = 1'b1;
    hold_left = HOLD_CYCLES;
    repeat (150) run_walk(10'($urandom));
    quiet = 1'b0;
  endtask

  task automatic test_random_phases();
    int ph, len, eff_len, pick, k;
    logic [5:0] depth;
    tstw_pkg::in_item_t it;
    ph = 0;
    while (items_sent < ITEM_TARGET) begin
      case (ph % 6)
        0: len = 2;
        1: len = 1024;
        2: len = $urandom_range(3, 64);
        3: len = $urandom_range(2, 40);
        4: begin
          pick = $urandom_range(0, 2);
          len = (pick == 0) ? 0 : (pick == 1) ? 1 : $urandom_range(1025, 2047);
        end
        default: len = $urandom_range(65, 1023);
      endcase
      case ($urandom_range(0, 5))
        0: depth = 6'd0;
        1: depth = 6'd63;
        2: depth = $urandom_range(1, 3);
        default: depth = $urandom_range(4, 12);
      endcase
      set_config(len[tstw_pkg::LEN_W-1:0], depth);
      eff_len = (len < 2) ? 2 : (len > tstw_pkg::SERIES_MAX) ? tstw_pkg::SERIES_MAX : len;
      build_tree($urandom_range(1, 15));
      if (eff_len <= 64) load_samples(eff_len);
      repeat (60) begin
        if (items_sent >= ITEM_TARGET) break;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          run_walk(10'($urandom));
        end else if (pick < 85) begin
          // Corrupt the tree: random links, kinds and depths, cycles included.
          it = random_item();
          it.func = tstw_pkg::FUNC_NODE_WR;
          if ($urandom_range(0, 1)) begin
            k = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
            it.node_index = k[9:0];
          end
          if ($urandom_range(0, 1)) begin
            k = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
            it.left_child = k[9:0];
          end
          it.threshold = rand_q();
          send_item(it);
        end else if (pick < 95) begin
          write_sample(10'($urandom_range(0, eff_len - 1)), rand_q());
        end else begin
          it = random_item();
          it.func = FUNC_NONE;
          send_item(it);
        end
      end
      ph++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    tstw_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (walk_results_q.size() == 0) begin
        $error("result beat with nothing pending: node %0d value %0d",
               out_data.final_node, out_data.final_value);
        errors++;
      end else begin
        want = walk_results_q.pop_front();
        if (out_data.final_node !== want.final_node) begin
          $error("final_node: expected %0d, got %0d", want.final_node, out_data.final_node);
          errors++;
        end
        if (out_data.final_value !== want.final_value) begin
          $error("final_value: expected %0d, got %0d", want.final_value,
                 out_data.final_value);
          errors++;
        end
      end
    end
  end

  initial begin
    node_written   = '{default: 1'b0};
    sample_written = '{default: 1'b0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_special_cases();
    test_output_backpressure();
    test_random_phases();
    in_valid <= 1'b0;
    while (walk_results_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tstw_pkg.sv
rtl/time_series_tree_walk_core.sv
tb/tb_time_series_tree_walk_core.sv
